>>> rtl/core/tcs_pkg.sv
package tcs_pkg;

	typedef enum logic [1:0] {
		PH_SILENCE = 2'd0,
		PH_TONE_A  = 2'd1,
		PH_TONE_B  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		STEP_LEAVE_OFF   = 3'd0,
		STEP_LEAVE_ON    = 3'd1,
		STEP_TURN_ON     = 3'd2,
		STEP_TURN_OFF    = 3'd3,
		STEP_CHANGE_FREQ = 3'd4
	} step_code_t;

	typedef enum logic [1:0] {
		REG_TONE_A_LENGTH    = 2'd0,
		REG_TONE_B_LENGTH    = 2'd1,
		REG_SILENCE_SHORTEST = 2'd2,
		REG_SILENCE_LONGEST  = 2'd3
	} reg_index_t;

	localparam logic ACTION_TICK  = 1'b0;
	localparam logic ACTION_START = 1'b1;

	localparam logic [15:0] TONE_A_LENGTH_RST    = 16'd2000;
	localparam logic [15:0] TONE_B_LENGTH_RST    = 16'd0;
	localparam logic [15:0] SILENCE_SHORTEST_RST = 16'd4000;
	localparam logic [15:0] SILENCE_LONGEST_RST  = 16'd4000;

endpackage

>>> rtl/core/tone_cadence_sequencer.sv
// Flow: a tick request enters the input register when it is accepted, and its result
// moves to the output register once that is free; a start request gives no result.
// Throughput: one request per cycle unless a tick waits on a stalled output.
// Reset: arst_n clears the cadence state and both pipeline stages at once and loads the
// timing registers with their defaults.
module tone_cadence_sequencer
	import tcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // now_ms[31:0], repeat_mode[32], random_draw[48:33]
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // step_code[2:0], tone_b_selected[3]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] tone_a_q;
	logic [15:0] tone_b_q;
	logic [15:0] sil_min_q;
	logic [15:0] sil_max_q;

	logic        running_q;
	logic        repeat_q;
	logic        sounding_q;
	phase_t      phase_q;
	logic [31:0] deadline_q;

	logic        running_d;
	logic        repeat_d;
	logic        sounding_d;
	phase_t      phase_d;
	logic [31:0] deadline_d;

	logic        valid_s1;
	logic        action_s1;
	logic [31:0] now_s1;
	logic        rep_s1;
	logic [16:0] sil_len_s1;

	logic        valid_s2;
	step_code_t  code_s2;
	logic        tone_b_s2;

	logic        in_accept;
	logic        s1_advance;
	logic        s1_tick;
	logic [15:0] span;
	logic [31:0] product;
	logic [16:0] sil_len;
	logic        reached;
	logic [16:0] next_len;
	step_code_t  code_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_a_q  <= TONE_A_LENGTH_RST;
			tone_b_q  <= TONE_B_LENGTH_RST;
			sil_min_q <= SILENCE_SHORTEST_RST;
			sil_max_q <= SILENCE_LONGEST_RST;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_TONE_A_LENGTH:    tone_a_q  <= cfg_data;
				REG_TONE_B_LENGTH:    tone_b_q  <= cfg_data;
				REG_SILENCE_SHORTEST: sil_min_q <= cfg_data;
				REG_SILENCE_LONGEST:  sil_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The silence length depends only on the request and the timing registers, so it is
	// worked out on the way into the input register.
	assign span    = (sil_max_q > sil_min_q) ? (sil_max_q - sil_min_q) : 16'd0;
	assign product = s_axis_tdata[48:33] * span;
	assign sil_len = {1'b0, sil_min_q} + {1'b0, product[31:16]};

	assign s1_advance    = valid_s1 && ((action_s1 == ACTION_START) || !valid_s2 || m_axis_tready);
	assign s1_tick       = s1_advance && (action_s1 == ACTION_TICK);
	assign s_axis_tready = !valid_s1 || s1_advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1  <= s_axis_tuser;
			now_s1     <= s_axis_tdata[31:0];
			rep_s1     <= s_axis_tdata[32];
			sil_len_s1 <= sil_len;
		end
	end

	assign reached = now_s1 >= deadline_q;

	always_comb begin
		unique case (phase_q)
			PH_TONE_A: next_len = {1'b0, tone_b_q};
			PH_TONE_B: next_len = sil_len_s1;
			default:   next_len = {1'b0, tone_a_q};
		endcase
	end

	always_comb begin
		running_d  = running_q;
		repeat_d   = repeat_q;
		sounding_d = sounding_q;
		phase_d    = phase_q;
		deadline_d = deadline_q;
		priority if (action_s1 == ACTION_START) begin
			running_d  = 1'b1;
			repeat_d   = rep_s1;
			sounding_d = 1'b1;
			phase_d    = PH_TONE_A;
			deadline_d = 32'd0;
		end else if (!running_q) begin
		end else if (deadline_q == 32'd0) begin
			deadline_d = now_s1 + {16'd0, tone_a_q};
		end else if (reached) begin
			unique case (phase_q)
				PH_TONE_A: begin
					phase_d    = PH_TONE_B;
					sounding_d = 1'b1;
					deadline_d = now_s1 + {15'd0, next_len};
				end
				PH_TONE_B: begin
					phase_d    = PH_SILENCE;
					sounding_d = 1'b0;
					if (repeat_q) begin
						deadline_d = now_s1 + {15'd0, next_len};
					end else begin
						running_d  = 1'b0;
						deadline_d = 32'd0;
					end
				end
				default: begin
					phase_d    = PH_TONE_A;
					sounding_d = 1'b1;
					deadline_d = now_s1 + {15'd0, next_len};
				end
			endcase
		end
	end

	always_comb begin
		priority if (!running_q) begin
			code_d = STEP_LEAVE_OFF;
		end else if (deadline_q == 32'd0) begin
			code_d = STEP_TURN_ON;
		end else if (!reached) begin
			code_d = sounding_q ? STEP_LEAVE_ON : STEP_LEAVE_OFF;
		end else if (!running_d) begin
			code_d = STEP_LEAVE_OFF;
		end else if (sounding_d && !sounding_q) begin
			code_d = STEP_TURN_ON;
		end else if (!sounding_d && sounding_q) begin
			code_d = STEP_TURN_OFF;
		end else if (sounding_d && (phase_d != phase_q)) begin
			code_d = STEP_CHANGE_FREQ;
		end else if (sounding_d) begin
			code_d = STEP_LEAVE_ON;
		end else begin
			code_d = STEP_LEAVE_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			repeat_q   <= 1'b0;
			sounding_q <= 1'b0;
			phase_q    <= PH_SILENCE;
			deadline_q <= 32'd0;
		end else if (s1_advance) begin
			running_q  <= running_d;
			repeat_q   <= repeat_d;
			sounding_q <= sounding_d;
			phase_q    <= phase_d;
			deadline_q <= deadline_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_tick) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_tick) begin
			code_s2   <= code_d;
			tone_b_s2 <= (phase_d == PH_TONE_B);
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, tone_b_s2, code_s2};

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (!sounding_q && (phase_q == PH_SILENCE) && (deadline_q == 32'd0)))
		else $error("idle sequencer holds stale cadence state");

	a_sound_phase: assert property (@(posedge clk) disable iff (!arst_n)
		sounding_q == (phase_q != PH_SILENCE))
		else $error("sounding flag disagrees with phase");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_tick |=> valid_s2)
		else $error("tick request left no result");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tcs_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;

	typedef struct packed {
		step_code_t code;
		logic       tone_b;
	} tone_step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;   // now_ms[31:0], repeat_mode[32], random_draw[48:33]
	logic        s_axis_tuser = 1'b0; // action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // step_code[2:0], tone_b_selected[3]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	bit          no_gaps = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned stall_cycles;
	logic [31:0] clock_ms = '0;
	tone_step_t  pending_steps[$];
	tone_step_t  head_step;

	logic [15:0] len_tone_a = TONE_A_LENGTH_RST;
	logic [15:0] len_tone_b = TONE_B_LENGTH_RST;
	logic [15:0] sil_min = SILENCE_SHORTEST_RST;
	logic [15:0] sil_max = SILENCE_LONGEST_RST;

	logic        cad_running = 1'b0;
	logic        cad_repeat_on = 1'b0;
	logic        cad_sounding = 1'b0;
	phase_t      cad_phase = PH_SILENCE;
	logic [31:0] cad_deadline = '0;

	tone_cadence_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 36);
	end

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Advances the expected cadence state by one request and queues the step that a tick produces.
	task automatic track_cadence(input logic act, input logic [31:0] now, input logic rep,
			input logic [15:0] draw);
		logic       was_on;
		phase_t     old_phase;
		step_code_t step;
		logic [31:0] span;
		logic [31:0] prod;
		if (act == ACTION_START) begin
			cad_repeat_on = rep;
			cad_running = 1'b1;
			cad_phase = PH_TONE_A;
			cad_sounding = 1'b1;
			cad_deadline = '0;
		end else begin
			if (!cad_running) begin
				step = STEP_LEAVE_OFF;
			end else if (cad_deadline == 32'd0) begin
				cad_deadline = now + {16'd0, len_tone_a};
				step = STEP_TURN_ON;
			end else if (now < cad_deadline) begin
				step = cad_sounding ? STEP_LEAVE_ON : STEP_LEAVE_OFF;
			end else begin
				was_on = cad_sounding;
				old_phase = cad_phase;
				case (cad_phase)
					PH_TONE_A: begin
						cad_phase = PH_TONE_B;
						cad_sounding = 1'b1;
						cad_deadline = now + {16'd0, len_tone_b};
					end
					PH_TONE_B: begin
						cad_phase = PH_SILENCE;
						cad_sounding = 1'b0;
						if (cad_repeat_on) begin
							span = (sil_max > sil_min) ? {16'd0, sil_max - sil_min} : 32'd0;
							prod = {16'd0, draw} * span;
							cad_deadline = now + {16'd0, sil_min} + (prod >> 16);
						end else begin
							cad_running = 1'b0;
							cad_deadline = '0;
						end
					end
					default: begin
						cad_phase = PH_TONE_A;
						cad_sounding = 1'b1;
						cad_deadline = now + {16'd0, len_tone_a};
					end
				endcase
				if (!cad_running)
					step = STEP_LEAVE_OFF;
				else if (cad_sounding && !was_on)
					step = STEP_TURN_ON;
				else if (!cad_sounding && was_on)
					step = STEP_TURN_OFF;
				else if (cad_sounding && cad_phase != old_phase)
					step = STEP_CHANGE_FREQ;
				else if (cad_sounding)
					step = STEP_LEAVE_ON;
				else
					step = STEP_LEAVE_OFF;
			end
			pending_steps.push_back('{code: step, tone_b: (cad_phase == PH_TONE_B)});
		end
	endtask

	task automatic send_request(input logic act, input logic [31:0] now, input logic rep,
			input logic [15:0] draw);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser <= act;
		s_axis_tdata <= {7'd0, draw, rep, now};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		track_cadence(act, now, rep, draw);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_steps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input reg_index_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TONE_A_LENGTH:    len_tone_a = value;
			REG_TONE_B_LENGTH:    len_tone_b = value;
			REG_SILENCE_SHORTEST: sil_min = value;
			default:              sil_max = value;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_timing(input logic [15:0] tone_a, input logic [15:0] tone_b,
			input logic [15:0] shortest, input logic [15:0] longest);
		drain_results();
		write_register(REG_TONE_A_LENGTH, tone_a);
		write_register(REG_TONE_B_LENGTH, tone_b);
		write_register(REG_SILENCE_SHORTEST, shortest);
		write_register(REG_SILENCE_LONGEST, longest);
	endtask

	// Mostly ticks, many of them aimed at the next deadline, so that every phase change is reached.
	task automatic run_cadence_traffic(input int unsigned count);
		int unsigned n;
		int unsigned pick;
		if ($urandom_range(0, 1) != 0) begin
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
		end
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if ((!cad_running && pick < 45) || pick < 4) begin
				send_request(ACTION_START, $urandom, $urandom_range(0, 3) != 0, 16'($urandom));
			end else begin
				if (pick < 12)
					clock_ms = $urandom;
				else if (cad_running && cad_deadline != 32'd0 && pick < 55)
					clock_ms = cad_deadline - 32'd1 + $urandom_range(0, 2);
				else
					clock_ms = clock_ms + $urandom_range(0, 3);
				send_request(ACTION_TICK, clock_ms, 1'($urandom_range(0, 1)), 16'($urandom));
			end
		end
	endtask

	task automatic test_idle_ticks();
		send_request(ACTION_TICK, 32'h0000_0000, 1'b0, 16'h0000);
		send_request(ACTION_TICK, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
	endtask

	task automatic test_single_tone_defaults();
		send_request(ACTION_START, 32'd0, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd1000, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd2999, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd3000, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd3000, 1'b0, 16'd0);
	endtask

	task automatic test_repeating_cadence();
		apply_timing(16'd10, 16'd5, 16'd20, 16'd30);
		send_request(ACTION_START, 32'd0, 1'b1, 16'd0);
		send_request(ACTION_TICK, 32'd100, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd105, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd110, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd115, 1'b0, 16'hFFFF);
		send_request(ACTION_TICK, 32'd144, 1'b0, 16'd0);
		send_request(ACTION_START, 32'd0, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd150, 1'b0, 16'd0);
	endtask

	task automatic test_time_wrap();
		send_request(ACTION_START, 32'd0, 1'b1, 16'd0);
		send_request(ACTION_TICK, 32'hFFFF_FFF6, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'hFFFF_FFF8, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'hFFFF_FFF9, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'hFFFF_FFFF, 1'b0, 16'h8000);
		send_request(ACTION_TICK, 32'h0000_0000, 1'b0, 16'd0);
	endtask

	task automatic test_inverted_bounds();
		apply_timing(16'd3, 16'd0, 16'd30, 16'd20);
		send_request(ACTION_START, 32'd0, 1'b1, 16'd0);
		send_request(ACTION_TICK, 32'd10, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd13, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd13, 1'b0, 16'hFFFF);
		send_request(ACTION_TICK, 32'd42, 1'b0, 16'd0);
		send_request(ACTION_TICK, 32'd43, 1'b0, 16'd0);
	endtask

	task automatic test_random_cadences();
		apply_timing(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
			16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
		run_cadence_traffic(200);
		apply_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_cadence_traffic(150);
		apply_timing(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
		run_cadence_traffic(150);
		apply_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_cadence_traffic(200);
		apply_timing(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
		run_cadence_traffic(150);
	endtask

	task automatic test_back_to_back();
		apply_timing(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
			16'($urandom_range(0, 20)), 16'($urandom_range(0, 60)));
		no_gaps = 1'b1;
		run_cadence_traffic(200);
		drain_results();
		no_gaps = 1'b0;
	endtask

	task automatic test_holdoff();
		run_cadence_traffic(120);
		drain_results();
		run_cadence_traffic(120);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_steps.size() == 0) begin
				flag_error($sformatf("unexpected result, tdata %h", m_axis_tdata));
			end else begin
				head_step = pending_steps.pop_front();
				if (m_axis_tdata[2:0] !== head_step.code) begin
					flag_error($sformatf("step_code mismatch: expected %0d, got %0d",
						head_step.code, m_axis_tdata[2:0]));
				end
				if (m_axis_tdata[3] !== head_step.tone_b) begin
					flag_error($sformatf("tone_b_selected mismatch: expected %0b, got %0b",
						head_step.tone_b, m_axis_tdata[3]));
				end
			end
		end
	end

	initial begin : watchdog
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_ticks();
		test_single_tone_defaults();
		test_repeating_cadence();
		test_time_wrap();
		test_inverted_bounds();
		test_random_cadences();
		test_back_to_back();
		test_holdoff();
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

>>> tone_cadence_sequencer.f
rtl/core/tcs_pkg.sv
rtl/core/tone_cadence_sequencer.sv
bench/tb_top.sv
